FILE: rtl/gcpb_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the glyph coverage pixel blender
// no dependencies; imported by every module of the block

package gcpb_pkg;

    // coordinate width of the pixel ports, two's complement
    localparam int COORD_WIDTH = 12;
    // surface dimension width
    localparam int DIM_W       = 11;
    // signed compare width that holds both a coordinate and a dimension
    localparam int CMP_W       = ((COORD_WIDTH > DIM_W) ? COORD_WIDTH : DIM_W) + 1;
    localparam int CHAN_W      = 8;
    localparam int ADDR_W      = 5;
    localparam int DATA_W      = 32;

    typedef enum logic [2:0] {
        REG_TEXT_RED       = 3'd0,
        REG_TEXT_GREEN     = 3'd1,
        REG_TEXT_BLUE      = 3'd2,
        REG_GLOBAL_ALPHA   = 3'd3,
        REG_ALPHA_ENABLE   = 3'd4,
        REG_PIXEL_FORMAT   = 3'd5,
        REG_SURFACE_WIDTH  = 3'd6,
        REG_SURFACE_HEIGHT = 3'd7
    } t_reg_idx;

    localparam logic FMT_RGB565 = 1'b0;
    localparam logic FMT_XRGB32 = 1'b1;

    typedef struct packed {
        logic [CHAN_W-1:0] text_red;
        logic [CHAN_W-1:0] text_green;
        logic [CHAN_W-1:0] text_blue;
        logic [CHAN_W-1:0] global_alpha;
        logic              alpha_enable;
        logic              pixel_format;
        logic [DIM_W-1:0]  surface_width;
        logic [DIM_W-1:0]  surface_height;
    } t_cfg;

    // register defaults: everything zero but a fully opaque global alpha
    localparam t_cfg CFG_RESET = '{
        text_red:       8'h00,
        text_green:     8'h00,
        text_blue:      8'h00,
        global_alpha:   8'hFF,
        alpha_enable:   1'b0,
        pixel_format:   FMT_RGB565,
        surface_width:  11'd0,
        surface_height: 11'd0
    };

endpackage

FILE: rtl/gcpb_regs.sv
`timescale 1ns / 1ps
// apb configuration register file of the blender
// depends on gcpb_pkg

module gcpb_regs import gcpb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[4:2]);
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            unique case (w_idx)
                REG_TEXT_RED:       n_cfg.text_red       = pwdata[CHAN_W-1:0];
                REG_TEXT_GREEN:     n_cfg.text_green     = pwdata[CHAN_W-1:0];
                REG_TEXT_BLUE:      n_cfg.text_blue      = pwdata[CHAN_W-1:0];
                REG_GLOBAL_ALPHA:   n_cfg.global_alpha   = pwdata[CHAN_W-1:0];
                REG_ALPHA_ENABLE:   n_cfg.alpha_enable   = pwdata[0];
                REG_PIXEL_FORMAT:   n_cfg.pixel_format   = pwdata[0];
                REG_SURFACE_WIDTH:  n_cfg.surface_width  = pwdata[DIM_W-1:0];
                REG_SURFACE_HEIGHT: n_cfg.surface_height = pwdata[DIM_W-1:0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_TEXT_RED:       prdata = DATA_W'(r_cfg.text_red);
            REG_TEXT_GREEN:     prdata = DATA_W'(r_cfg.text_green);
            REG_TEXT_BLUE:      prdata = DATA_W'(r_cfg.text_blue);
            REG_GLOBAL_ALPHA:   prdata = DATA_W'(r_cfg.global_alpha);
            REG_ALPHA_ENABLE:   prdata = DATA_W'(r_cfg.alpha_enable);
            REG_PIXEL_FORMAT:   prdata = DATA_W'(r_cfg.pixel_format);
            REG_SURFACE_WIDTH:  prdata = DATA_W'(r_cfg.surface_width);
            REG_SURFACE_HEIGHT: prdata = DATA_W'(r_cfg.surface_height);
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

FILE: rtl/gcpb_chan.sv
`timescale 1ns / 1ps
// one color channel of the blend: registered product, then floor step
// depends on gcpb_pkg

module gcpb_chan import gcpb_pkg::*; (
    input  logic              i_clk,
    input  logic [CHAN_W-1:0] i_old,
    input  logic [CHAN_W-1:0] i_color,
    input  logic [CHAN_W-1:0] i_weight,
    output logic [CHAN_W-1:0] o_chan
);

    logic [CHAN_W-1:0]   w_mag;
    logic                w_neg;
    logic [2*CHAN_W-1:0] r_prod;
    logic [CHAN_W-1:0]   r_old;
    logic                r_neg;
    logic [2*CHAN_W:0]   w_round;

    // magnitude of color minus old, sign kept aside
    assign w_neg = i_color < i_old;
    assign w_mag = w_neg ? (i_old - i_color) : (i_color - i_old);

    always_ff @(posedge i_clk) begin
        r_prod <= i_weight * w_mag;
        r_old  <= i_old;
        r_neg  <= w_neg;
    end

    // arithmetic shift of a negative product rounds toward minus infinity
    assign w_round = {1'b0, r_prod} + (2*CHAN_W+1)'(8'hFF);
    assign o_chan  = r_neg ? (r_old - w_round[2*CHAN_W-1:CHAN_W])
                           : (r_old + r_prod[2*CHAN_W-1:CHAN_W]);

endmodule

FILE: rtl/glyph_coverage_pixel_blender_unit.sv
`timescale 1ns / 1ps
// top level of the glyph coverage pixel blender: three-stage pipeline
// depends on gcpb_pkg, gcpb_regs, gcpb_chan
//
// channel  | signals                                        | direction
// ---------+------------------------------------------------+----------
// command  | start, busy, i_pixel_x/y, i_coverage,           | in
//          | i_dest_pixel                                   |
// result   | o_valid, o_new_pixel, o_write_enable           | out
// config   | psel, penable, pwrite, paddr, pwdata, prdata,  | apb
//          | pready                                         |
//
// one item per clock; busy is never raised, the pipeline always advances
// start to o_valid runs through three registered stages: clip and weight
// multiply, channel products, floor step and repack
// reset clears the valid bits and loads the register defaults
// the receiver takes every result on its strobe cycle, so nothing stalls

module glyph_coverage_pixel_blender_unit import gcpb_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command channel
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] i_pixel_x,
    input  logic signed [COORD_WIDTH-1:0] i_pixel_y,
    input  logic [7:0]                    i_coverage,
    input  logic [31:0]                   i_dest_pixel,
    // result channel
    output logic                          o_valid,
    output logic [31:0]                   o_new_pixel,
    output logic                          o_write_enable,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ADDR_W-1:0]             paddr,
    input  logic [DATA_W-1:0]             pwdata,
    output logic [DATA_W-1:0]             prdata,
    output logic                          pready
);

    t_cfg w_cfg;

    // stage 1 registers: clip result, weight, unpacked channels
    logic              r1_valid;
    logic              r1_wr;
    logic [31:0]       r1_pix;
    logic [CHAN_W-1:0] r1_weight;
    logic [CHAN_W-1:0] r1_old_r;
    logic [CHAN_W-1:0] r1_old_g;
    logic [CHAN_W-1:0] r1_old_b;
    // stage 2 registers (products live inside the channel units)
    logic              r2_valid;
    logic              r2_wr;
    logic [31:0]       r2_pix;
    // stage 3 output registers
    logic              r3_valid;
    logic              r3_wr;
    logic [31:0]       r3_pix;

    logic                    w_accept;
    logic signed [CMP_W-1:0] w_x;
    logic signed [CMP_W-1:0] w_y;
    logic signed [CMP_W-1:0] w_wd;
    logic signed [CMP_W-1:0] w_ht;
    logic                    n_wr;
    logic [2*CHAN_W-1:0]     w_alpha_prod;
    logic [CHAN_W-1:0]       n_weight;
    logic [CHAN_W-1:0]       n_old_r;
    logic [CHAN_W-1:0]       n_old_g;
    logic [CHAN_W-1:0]       n_old_b;
    logic [CHAN_W-1:0]       w_new_r;
    logic [CHAN_W-1:0]       w_new_g;
    logic [CHAN_W-1:0]       w_new_b;
    logic [31:0]             n_pix;

    gcpb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    // ---- stage 1: clip test and coverage weight ----
    // coordinates sign-extend, dimensions zero-extend, so one signed
    // compare per axis covers the negative side as well
    assign w_x  = CMP_W'(i_pixel_x);
    assign w_y  = CMP_W'(i_pixel_y);
    assign w_wd = $signed(CMP_W'(w_cfg.surface_width));
    assign w_ht = $signed(CMP_W'(w_cfg.surface_height));

    assign n_wr = (i_coverage != 8'd0) &&
                  (w_x >= 0) && (w_y >= 0) && (w_x < w_wd) && (w_y < w_ht);

    // with alpha enabled, global alpha scales coverage as (alpha * coverage) >> 8
    assign w_alpha_prod = w_cfg.global_alpha * i_coverage;
    assign n_weight     = w_cfg.alpha_enable ? w_alpha_prod[2*CHAN_W-1:CHAN_W]
                                             : i_coverage;

    // unpack to 8-bit channels; rgb565 fields widen by a plain shift
    always_comb begin
        if (w_cfg.pixel_format == FMT_RGB565) begin
            n_old_r = {i_dest_pixel[15:11], 3'b000};
            n_old_g = {i_dest_pixel[10:5],  2'b00};
            n_old_b = {i_dest_pixel[4:0],   3'b000};
        end else begin
            n_old_r = i_dest_pixel[23:16];
            n_old_g = i_dest_pixel[15:8];
            n_old_b = i_dest_pixel[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r1_wr    <= 1'b0;
        end else begin
            r1_valid <= w_accept;
            r1_wr    <= w_accept && n_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_pix    <= i_dest_pixel;
        r1_weight <= n_weight;
        r1_old_r  <= n_old_r;
        r1_old_g  <= n_old_g;
        r1_old_b  <= n_old_b;
    end

    // ---- stage 2: per-channel products, stage 3 floor step inside ----
    gcpb_chan u_chan_r (
        .i_clk    (i_clk),
        .i_old    (r1_old_r),
        .i_color  (w_cfg.text_red),
        .i_weight (r1_weight),
        .o_chan   (w_new_r)
    );

    gcpb_chan u_chan_g (
        .i_clk    (i_clk),
        .i_old    (r1_old_g),
        .i_color  (w_cfg.text_green),
        .i_weight (r1_weight),
        .o_chan   (w_new_g)
    );

    gcpb_chan u_chan_b (
        .i_clk    (i_clk),
        .i_old    (r1_old_b),
        .i_color  (w_cfg.text_blue),
        .i_weight (r1_weight),
        .o_chan   (w_new_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
            r2_wr    <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
            r2_wr    <= r1_valid && r1_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_pix <= r1_pix;
    end

    // ---- stage 3: repack; unwritten items pass the old pixel through ----
    always_comb begin
        if (!r2_wr) begin
            n_pix = r2_pix;
        end else if (w_cfg.pixel_format == FMT_RGB565) begin
            n_pix = {r2_pix[31:16], w_new_r[7:3], w_new_g[7:2], w_new_b[7:3]};
        end else begin
            n_pix = {r2_pix[31:24], w_new_r, w_new_g, w_new_b};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
            r3_wr    <= 1'b0;
        end else begin
            r3_valid <= r2_valid;
            r3_wr    <= r2_valid && r2_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_pix <= n_pix;
    end

    assign o_valid        = r3_valid;
    assign o_write_enable = r3_wr;
    assign o_new_pixel    = r3_pix;

    // ---- checks ----
    a_we_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_write_enable |-> o_valid)
        else $error("write enable without a result strobe");

    a_skip_passes_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_write_enable) |-> (o_new_pixel == $past(i_dest_pixel, 3)))
        else $error("unwritten item changed the pixel");

    a_565_upper_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && w_cfg.pixel_format == FMT_RGB565)
            |-> (o_new_pixel[31:16] == $past(i_dest_pixel[31:16], 3)))
        else $error("rgb565 upper half disturbed");

    a_32_top_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && w_cfg.pixel_format == FMT_XRGB32)
            |-> (o_new_pixel[31:24] == $past(i_dest_pixel[31:24], 3)))
        else $error("top byte of 32-bit pixel disturbed");

endmodule

FILE: tb/sv/gcpb_checker.sv
`timescale 1ns / 1ps
// result checker for the glyph coverage pixel blender: mirrors the registers,
// predicts each blended pixel and compares it; depends on gcpb_pkg only

module gcpb_checker import gcpb_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_busy,
    input  logic signed [COORD_WIDTH-1:0] i_pixel_x,
    input  logic signed [COORD_WIDTH-1:0] i_pixel_y,
    input  logic [7:0]                    i_coverage,
    input  logic [31:0]                   i_dest_pixel,
    input  logic                          i_valid,
    input  logic [31:0]                   i_new_pixel,
    input  logic                          i_write_enable,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic                          i_pready,
    input  logic [ADDR_W-1:0]             i_paddr,
    input  logic [DATA_W-1:0]             i_pwdata,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_checked
);

    typedef struct packed {
        logic [31:0] pixel;
        logic        wr_en;
    } t_blend_out;

    t_cfg       regs;
    t_blend_out pending_pixels[$];
    int         mismatches = 0;
    int         in_flight  = 0;
    int         compared   = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = in_flight;
    assign o_checked    = compared;

    // old + floor(weight * (color - old) / 256)
    function automatic logic [7:0] mix_channel(logic [7:0] old, logic [7:0] color,
                                               logic [7:0] weight);
        int diff;
        int prod;
        diff = int'(color) - int'(old);
        prod = int'(weight) * diff;
        return 8'(int'(old) + (prod >>> 8));
    endfunction

    function automatic t_blend_out blend_pixel(t_cfg c,
                                               logic signed [COORD_WIDTH-1:0] x,
                                               logic signed [COORD_WIDTH-1:0] y,
                                               logic [7:0] cov, logic [31:0] pix);
        t_blend_out  r;
        logic [15:0] alpha_prod;
        logic [7:0]  w;
        logic [7:0]  red;
        logic [7:0]  grn;
        logic [7:0]  blu;
        bit          in_bounds;
        r.pixel = pix;
        r.wr_en = 1'b0;
        in_bounds = (int'(x) >= 0) && (int'(y) >= 0) &&
                    (int'(x) < int'(c.surface_width)) &&
                    (int'(y) < int'(c.surface_height));
        if (cov == 8'd0 || !in_bounds)
            return r;
        alpha_prod = c.global_alpha * cov;
        w = c.alpha_enable ? alpha_prod[15:8] : cov;
        if (c.pixel_format == FMT_RGB565) begin
            red = mix_channel({pix[15:11], 3'b000}, c.text_red, w);
            grn = mix_channel({pix[10:5], 2'b00}, c.text_green, w);
            blu = mix_channel({pix[4:0], 3'b000}, c.text_blue, w);
            r.pixel = {pix[31:16], red[7:3], grn[7:2], blu[7:3]};
        end else begin
            red = mix_channel(pix[23:16], c.text_red, w);
            grn = mix_channel(pix[15:8], c.text_green, w);
            blu = mix_channel(pix[7:0], c.text_blue, w);
            r.pixel = {pix[31:24], red, grn, blu};
        end
        r.wr_en = 1'b1;
        return r;
    endfunction

    task automatic apply_write(logic [2:0] idx, logic [DATA_W-1:0] data);
        case (t_reg_idx'(idx))
            REG_TEXT_RED:       regs.text_red       = data[CHAN_W-1:0];
            REG_TEXT_GREEN:     regs.text_green     = data[CHAN_W-1:0];
            REG_TEXT_BLUE:      regs.text_blue      = data[CHAN_W-1:0];
            REG_GLOBAL_ALPHA:   regs.global_alpha   = data[CHAN_W-1:0];
            REG_ALPHA_ENABLE:   regs.alpha_enable   = data[0];
            REG_PIXEL_FORMAT:   regs.pixel_format   = data[0];
            REG_SURFACE_WIDTH:  regs.surface_width  = data[DIM_W-1:0];
            REG_SURFACE_HEIGHT: regs.surface_height = data[DIM_W-1:0];
            default: ;
        endcase
    endtask

    task automatic flag(string what, logic [31:0] exp_v, logic [31:0] act_v);
        mismatches++;
        if (mismatches <= 10)
            $display("gcpb_checker: %s at %0t: expected %h, got %h",
                     what, $time, exp_v, act_v);
    endtask

    always @(posedge i_clk) begin : watch
        t_blend_out want;
        if (!i_rst_n) begin
            regs = '0;
            regs.global_alpha = 8'hFF;
            pending_pixels.delete();
        end else begin
            if (i_valid) begin
                if (pending_pixels.size() == 0) begin
                    flag("result with nothing pending", 32'h0, i_new_pixel);
                end else begin
                    want = pending_pixels.pop_front();
                    compared++;
                    if (i_new_pixel !== want.pixel)
                        flag("new_pixel", want.pixel, i_new_pixel);
                    if (i_write_enable !== want.wr_en)
                        flag("write_enable", 32'(want.wr_en), 32'(i_write_enable));
                end
            end
            if (i_start && !i_busy)
                pending_pixels.push_back(blend_pixel(regs, i_pixel_x, i_pixel_y,
                                                     i_coverage, i_dest_pixel));
            if (i_psel && i_penable && i_pwrite && i_pready)
                apply_write(i_paddr[ADDR_W-1:2], i_pwdata);
        end
        in_flight = pending_pixels.size();
    end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// top of the glyph coverage pixel blender testbench: clock, reset, register
// writes and pixel stimulus; depends on gcpb_pkg, gcpb_checker and the block

module tb_top;
    import gcpb_pkg::*;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // command channel, all driven to known values from time zero
    logic                          start        = 1'b0;
    logic                          busy;
    logic signed [COORD_WIDTH-1:0] i_pixel_x    = '0;
    logic signed [COORD_WIDTH-1:0] i_pixel_y    = '0;
    logic [7:0]                    i_coverage   = '0;
    logic [31:0]                   i_dest_pixel = '0;

    // result channel, the receiver always takes the item on its strobe
    logic        o_valid;
    logic [31:0] o_new_pixel;
    logic        o_write_enable;

    // register port
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [DATA_W-1:0] pwdata  = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // checker status
    int fail_count;
    int pending;
    int checked;

    // run bookkeeping
    int         items_sent    = 0;
    int         settings_used = 0;
    logic [10:0] cur_w        = '0;
    logic [10:0] cur_h        = '0;

    // 12 ns period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    glyph_coverage_pixel_blender_unit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_pixel_x      (i_pixel_x),
        .i_pixel_y      (i_pixel_y),
        .i_coverage     (i_coverage),
        .i_dest_pixel   (i_dest_pixel),
        .o_valid        (o_valid),
        .o_new_pixel    (o_new_pixel),
        .o_write_enable (o_write_enable),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    gcpb_checker pixel_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_pixel_x      (i_pixel_x),
        .i_pixel_y      (i_pixel_y),
        .i_coverage     (i_coverage),
        .i_dest_pixel   (i_dest_pixel),
        .i_valid        (o_valid),
        .i_new_pixel    (o_new_pixel),
        .i_write_enable (o_write_enable),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_pready       (pready),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked)
    );

    // present one item and hold it until the block takes it
    // start stays high on return so back-to-back items need no extra edge
    task automatic send_pixel(int x, int y, int cov, logic [31:0] pix);
        start        <= 1'b1;
        i_pixel_x    <= COORD_WIDTH'(x);
        i_pixel_y    <= COORD_WIDTH'(y);
        i_coverage   <= 8'(cov);
        i_dest_pixel <= pix;
        do @(posedge i_clk); while (busy);
        items_sent++;
    endtask

    // sender gap with start low, lands on any pipeline stage
    task automatic pause_sender(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // stop sending until every predicted pixel is back, then let the
    // three-stage pipeline settle; sampled on the falling edge to stay
    // clear of the checker's update at the rising edge
    task automatic wait_drained();
        start <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // setup then access phase; back-to-back writes go straight from
    // access to the next setup
    task automatic apb_write(t_reg_idx idx, logic [DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
    endtask

    // full register load, only with the pipeline empty
    task automatic load_settings(int red, int grn, int blu, int alpha,
                                 logic alpha_en, logic fmt, int w, int h);
        wait_drained();
        apb_write(REG_TEXT_RED,       DATA_W'(red));
        apb_write(REG_TEXT_GREEN,     DATA_W'(grn));
        apb_write(REG_TEXT_BLUE,      DATA_W'(blu));
        apb_write(REG_GLOBAL_ALPHA,   DATA_W'(alpha));
        apb_write(REG_ALPHA_ENABLE,   DATA_W'(alpha_en));
        apb_write(REG_PIXEL_FORMAT,   DATA_W'(fmt));
        apb_write(REG_SURFACE_WIDTH,  DATA_W'(w));
        apb_write(REG_SURFACE_HEIGHT, DATA_W'(h));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        cur_w = 11'(w);
        cur_h = 11'(h);
        settings_used++;
    endtask

    // mostly inside the surface, some right on the clip edge, rest anywhere
    // in the signed range
    function automatic int pick_coord(int span);
        int roll = $urandom_range(0, 19);
        if (roll == 0)
            return span;
        if (roll == 1)
            return span - 1;
        if (roll < 15 && span > 0)
            return $urandom_range(0, span - 1);
        return int'($urandom);
    endfunction

    // coverage leans on zero, full and the lowest nonzero value
    function automatic int pick_coverage();
        int roll = $urandom_range(0, 9);
        if (roll == 0)
            return 0;
        if (roll == 1)
            return 255;
        if (roll == 2)
            return 1;
        return $urandom_range(0, 255);
    endfunction

    function automatic int pick_size();
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, 16);
        return $urandom_range(1, 2047);
    endfunction

    initial begin : stimulus
        int phase;
        int n;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: full surface, coverage without alpha, rgb565
        load_settings(255, 0, 128, 255, 1'b0, FMT_RGB565, 2047, 2047);
        send_pixel(0, 0, 255, 32'h0000_0000);
        send_pixel(2046, 2046, 255, 32'hFFFF_FFFF);
        send_pixel(2047, 10, 200, 32'h1357_9BDF);        // right edge clipped
        send_pixel(10, 2047, 200, 32'h2468_ACE0);        // bottom edge clipped
        send_pixel(-1, 0, 255, 32'h0F0F_0F0F);           // negative x clipped
        send_pixel(0, -1, 255, 32'hF0F0_F0F0);           // negative y clipped
        send_pixel(-2048, -2048, 255, 32'h5555_AAAA);
        send_pixel(100, 100, 0, 32'hCAFE_1234);          // no coverage, not written
        send_pixel(5, 5, 1, 32'hA5A5_F81F);              // upper half passes through
        send_pixel(6, 6, 128, 32'h1234_07E0);
        send_pixel(7, 7, 255, 32'hFFFF_FFFF);            // color below old, floors

        // alpha zero: written but channels unchanged, 1x1 surface, 32-bit
        load_settings(0, 255, 0, 0, 1'b1, FMT_XRGB32, 1, 1);
        send_pixel(0, 0, 255, 32'hDEAD_BEEF);
        send_pixel(1, 0, 255, 32'hDEAD_BEEF);
        send_pixel(0, 1, 255, 32'hDEAD_BEEF);
        send_pixel(0, 0, 0, 32'hDEAD_BEEF);

        // alpha one scales full coverage down to zero weight
        load_settings(10, 200, 90, 1, 1'b1, FMT_XRGB32, 2047, 2047);
        send_pixel(0, 0, 255, 32'h00FF_00FF);
        send_pixel(2046, 0, 255, 32'h7F80_7F80);

        // full alpha, weight 254 at full coverage
        load_settings(10, 200, 90, 255, 1'b1, FMT_XRGB32, 2047, 2047);
        send_pixel(3, 4, 255, 32'hFF00_FF00);
        send_pixel(2046, 2046, 128, 32'h8080_8080);
        send_pixel(1, 1, 255, 32'h0000_0000);

        // empty surface clips everything
        load_settings(255, 255, 255, 255, 1'b0, FMT_RGB565, 0, 0);
        send_pixel(0, 0, 255, 32'hFFFF_0000);
        send_pixel(2047, 2047, 255, 32'h0000_FFFF);
        send_pixel(-2048, 0, 255, 32'h1111_2222);
        send_pixel(0, 2047, 255, 32'h3333_4444);

        // random: two extreme settings, then random ones
        for (phase = 0; phase < 6; phase++) begin
            if (phase == 0)
                load_settings(0, 0, 0, 0, 1'b1, FMT_RGB565, 2047, 2047);
            else if (phase == 1)
                load_settings(255, 255, 255, 255, 1'b1, FMT_XRGB32, 2047, 2047);
            else
                load_settings($urandom_range(0, 255), $urandom_range(0, 255),
                              $urandom_range(0, 255), $urandom_range(0, 255),
                              1'($urandom), 1'($urandom), pick_size(), pick_size());
            for (n = 0; n < 300; n++) begin
                // phase 3 runs without any sender gap
                if (phase != 3 && $urandom_range(0, 99) < 6)
                    pause_sender($urandom_range(1, 4));
                // hold off mid-phase until everything is back
                if (phase == 2 && n == 150)
                    wait_drained();
                send_pixel(pick_coord(int'(cur_w)), pick_coord(int'(cur_h)),
                           pick_coverage(), $urandom);
            end
        end

        wait_drained();
        $display("tb_top: %0d items over %0d register settings, %0d results compared",
                 items_sent, settings_used, checked);
        $display("tb_top: both pixel formats, alpha on and off, clipping on all four edges");
        if (fail_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

    // run limit, far above the length of a normal run
    initial begin : watchdog
        #3000000;
        $display("tb_top: done, errors");
        $finish;
    end

endmodule
